FILE: hdl/pi2rgba_pkg.sv
package pi2rgba_pkg;

  localparam int MAX_ROW_PIXELS  = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int ROW_W   = 13;
  localparam int POS_W   = $clog2(MAX_ROW_PIXELS);
  localparam int WIDTH_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CMP_W   = (WIDTH_W > ROW_W) ? WIDTH_W : ROW_W;
  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int TRN_DEPTH = 256;

  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_ALPHA   = 2'd2;

  localparam logic [1:0] CFG_DEPTH_CODE  = 2'd0;
  localparam logic [1:0] CFG_ROW_PIXELS  = 2'd1;
  localparam logic [1:0] CFG_OPAQUE_FROM = 2'd2;

  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_2 = 2'd1,
    DEPTH_4 = 2'd2,
    DEPTH_8 = 2'd3
  } depth_t;

  typedef struct packed {
    logic eor;
    logic last;
    logic use_alpha;
    logic in_pal;
  } pix_meta_t;

endpackage

FILE: hdl/pi2rgba_ram.sv
module pi2rgba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/palette_index_to_rgba.sv
// pipeline: unpacker register, memory read stage, output register; one result per cycle
//   from the palette memory read port while the output is not stalled; a byte holds the
//   input until its last index in the byte or row is issued, table writes one a cycle unless stalled
// reset (rst, synchronous): clears pipeline valids and pixel position, depth 8 bits,
//   row width 1, no transparency entries; table contents undefined until written
module palette_index_to_rgba (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  packed_byte,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_red,
  input  logic [7:0]  entry_green,
  input  logic [7:0]  entry_blue,
  input  logic [7:0]  entry_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        end_of_row,
  output logic        last_of_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  pi2rgba_pkg::depth_t                depth_code;
  logic [pi2rgba_pkg::ROW_W-1:0]      row_pixels;
  logic [8:0]                         opaque_from;
  logic [pi2rgba_pkg::POS_W-1:0]      pos;

  logic                               s1_valid;
  logic [7:0]                         sh;
  logic [3:0]                         cnt;

  logic                               s2_valid;
  pi2rgba_pkg::pix_meta_t             meta2;
  pi2rgba_pkg::pix_meta_t             meta1;

  logic [23:0]                        pal_rd;
  logic [7:0]                         trn_rd;

  logic [pi2rgba_pkg::CMP_W-1:0]      width;
  logic [pi2rgba_pkg::CMP_W-1:0]      rp_ext;
  logic [pi2rgba_pkg::POS_W-1:0]      pos_eff;
  logic [pi2rgba_pkg::CMP_W-1:0]      pos_inc;
  logic [7:0]                         cur_idx;
  logic [7:0]                         sh_next;
  logic [3:0]                         per_byte;
  logic                               out_free;
  logic                               s2_free;
  logic                               issue;
  logic                               in_acc;
  logic                               pal_we;
  logic                               trn_we;

  assign cfg_ready = 1'b1;

  always_comb begin
    rp_ext = pi2rgba_pkg::CMP_W'(row_pixels);
    if (rp_ext == '0) begin
      width = pi2rgba_pkg::CMP_W'(1);
    end else if (rp_ext > pi2rgba_pkg::CMP_W'(pi2rgba_pkg::MAX_ROW_PIXELS)) begin
      width = pi2rgba_pkg::CMP_W'(pi2rgba_pkg::MAX_ROW_PIXELS);
    end else begin
      width = rp_ext;
    end
    pos_eff = (pi2rgba_pkg::CMP_W'(pos) >= width) ? '0 : pos;
    pos_inc = pi2rgba_pkg::CMP_W'(pos_eff) + pi2rgba_pkg::CMP_W'(1);

    case (depth_code)
      pi2rgba_pkg::DEPTH_1: begin
        cur_idx = {7'b0, sh[7]};
        sh_next = {sh[6:0], 1'b0};
      end
      pi2rgba_pkg::DEPTH_2: begin
        cur_idx = {6'b0, sh[7:6]};
        sh_next = {sh[5:0], 2'b0};
      end
      pi2rgba_pkg::DEPTH_4: begin
        cur_idx = {4'b0, sh[7:4]};
        sh_next = {sh[3:0], 4'b0};
      end
      default: begin
        cur_idx = sh;
        sh_next = 8'b0;
      end
    endcase
    per_byte = 4'd8 >> depth_code;

    meta1.eor       = pos_inc >= width;
    meta1.last      = meta1.eor || (cnt == 4'd1);
    meta1.use_alpha = {1'b0, cur_idx} < opaque_from;
    meta1.in_pal    = {1'b0, cur_idx} < 9'(pi2rgba_pkg::PALETTE_ENTRIES);

    out_free = !out_valid || !out_stall;
    s2_free  = !s2_valid || out_free;
    issue    = s1_valid && s2_free;
    in_stall = s1_valid && !(issue && meta1.last);
    in_acc   = in_valid && !in_stall;

    pal_we = in_acc && (mode == pi2rgba_pkg::MODE_PALETTE) &&
             ({1'b0, entry_index} < 9'(pi2rgba_pkg::PALETTE_ENTRIES));
    trn_we = in_acc && (mode == pi2rgba_pkg::MODE_ALPHA);
  end

  pi2rgba_ram #(
    .WIDTH (24),
    .DEPTH (pi2rgba_pkg::PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (entry_index[pi2rgba_pkg::PAL_AW-1:0]),
    .wdata ({entry_red, entry_green, entry_blue}),
    .re    (issue),
    .raddr (cur_idx[pi2rgba_pkg::PAL_AW-1:0]),
    .rdata (pal_rd)
  );

  pi2rgba_ram #(
    .WIDTH (8),
    .DEPTH (pi2rgba_pkg::TRN_DEPTH)
  ) u_trn_ram (
    .clk   (clk),
    .we    (trn_we),
    .waddr (entry_index),
    .wdata (entry_alpha),
    .re    (issue),
    .raddr (cur_idx),
    .rdata (trn_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code  <= pi2rgba_pkg::DEPTH_8;
      row_pixels  <= pi2rgba_pkg::ROW_W'(1);
      opaque_from <= 9'd0;
      pos         <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pi2rgba_pkg::CFG_DEPTH_CODE:  depth_code  <= pi2rgba_pkg::depth_t'(cfg_data[1:0]);
          pi2rgba_pkg::CFG_ROW_PIXELS:  row_pixels  <= cfg_data;
          pi2rgba_pkg::CFG_OPAQUE_FROM: opaque_from <= cfg_data[8:0];
          default: ;
        endcase
      end

      // unpacker: one index per cycle into the memory read port while the read stage is free
      if (issue) begin
        pos <= meta1.eor ? '0 : pi2rgba_pkg::POS_W'(pos_inc);
      end
      if (in_acc && (mode == pi2rgba_pkg::MODE_PIXEL)) begin
        s1_valid <= 1'b1;
        sh       <= packed_byte;
        cnt      <= per_byte;
      end else if (issue) begin
        sh  <= sh_next;
        cnt <= cnt - 4'd1;
        if (meta1.last) begin
          s1_valid <= 1'b0;
        end
      end

      // memory read stage
      if (issue) begin
        s2_valid <= 1'b1;
        meta2    <= meta1;
      end else if (out_free) begin
        s2_valid <= 1'b0;
      end

      // output register
      if (s2_valid && out_free) begin
        out_valid    <= 1'b1;
        red          <= meta2.in_pal ? pal_rd[23:16] : 8'h00;
        green        <= meta2.in_pal ? pal_rd[15:8] : 8'h00;
        blue         <= meta2.in_pal ? pal_rd[7:0] : 8'h00;
        alpha        <= meta2.use_alpha ? trn_rd : 8'hff;
        end_of_row   <= meta2.eor;
        last_of_item <= meta2.last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_unpack_count: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (cnt != 4'd0))
    else $error("unpacker holds an item with no indices left");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && !(issue && meta1.last)))
    else $error("input held while unpacker can take an item");

  a_eor_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_row) |-> last_of_item)
    else $error("row end without last result of item");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !out_free) |=> (s2_valid && $stable(pal_rd) && $stable(trn_rd)))
    else $error("memory read data lost while output stalled");
`endif

endmodule
